>>> design/snrc_pkg.sv
// ---------------------------------------------------------------------------
// snrc_pkg
// Shared constants for the snr weighted bit combiner: snr width, copy count,
// register indexes, reset values and the refresh count.
// ---------------------------------------------------------------------------
`default_nettype none

package snrc_pkg;

  localparam int SNR_BITS_DEF = 8;
  localparam int NUM_COPIES   = 4;
  localparam int CFG_IDX_W    = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SNR_A = 2'd0,
    CFG_SNR_B = 2'd1,
    CFG_SNR_C = 2'd2,
    CFG_SNR_D = 2'd3
  } cfg_idx_t;

  // reset value of every snr register, quarter-dB units
  localparam int SNR_RESET = 4;

  // cycles from a configuration write until the cross-products are valid
  localparam int REFRESH_CYCLES = 2;
  localparam int REFRESH_CNT_W  = 2;

endpackage

`default_nettype wire

>>> design/snrc_in_if.sv
// ---------------------------------------------------------------------------
// snrc_in_if
// Request channel carrying one bit position from each of the four copies.
// ---------------------------------------------------------------------------
`default_nettype none

interface snrc_in_if;
  import snrc_pkg::*;

  logic valid;
  logic ready;
  logic copy_a_bit;
  logic copy_b_bit;
  logic copy_c_bit;
  logic copy_d_bit;

  modport source (
    output valid, copy_a_bit, copy_b_bit, copy_c_bit, copy_d_bit,
    input  ready
  );
  modport sink (
    input  valid, copy_a_bit, copy_b_bit, copy_c_bit, copy_d_bit,
    output ready
  );
endinterface

`default_nettype wire

>>> design/snrc_out_if.sv
// ---------------------------------------------------------------------------
// snrc_out_if
// Result channel carrying the combined bit decision.
// ---------------------------------------------------------------------------
`default_nettype none

interface snrc_out_if;
  import snrc_pkg::*;

  logic valid;
  logic ready;
  logic decided_bit;

  modport source (
    output valid, decided_bit,
    input  ready
  );
  modport sink (
    input  valid, decided_bit,
    output ready
  );
endinterface

`default_nettype wire

>>> design/snr_weighted_bit_combiner_top.sv
// ---------------------------------------------------------------------------
// snr_weighted_bit_combiner_top
// Combines four received copies of a bit by snr-weighted voting. Each copy's
// vote is scaled by the product of the other three snr magnitudes, so the
// decision is taken exactly in integer arithmetic.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake         payload
//  in_ch     in         valid/ready       copy_a_bit .. copy_d_bit
//  out_ch    out        valid/ready       decided_bit
//  cfg_*     in         write enable      cfg_index, cfg_data (SNR_BITS)
//
//  one request per cycle unless a stalled result or a refresh holds it off;
//  the result passes the input register, then the result register; the vote
//  adder and compare sit between them. a configuration write holds in_ch.ready
//  low while the two-stage multiplier chain refreshes the cross-products.
//  synchronous active-low reset; cross-products reset to 64 (all snr at 4).
//  a stalled result holds while the input register still takes a request if empty.
// ---------------------------------------------------------------------------
`default_nettype none

module snr_weighted_bit_combiner_top
  import snrc_pkg::*;
#(
  parameter int SNR_BITS = SNR_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  snrc_in_if.sink             in_ch,
  snrc_out_if.source          out_ch,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [SNR_BITS-1:0]  cfg_data
);

  localparam int PW2 = 2*SNR_BITS - 1;       // product of two magnitudes
  localparam int PW3 = 3*SNR_BITS - 2;       // product of three magnitudes
  localparam int SW  = PW3 + 2;              // sum of four cross-products
  localparam int VW  = SW + 3;               // sum scaled by a count up to 4

  localparam logic [SNR_BITS-1:0] SNR_RST = SNR_BITS'(SNR_RESET);
  localparam logic [PW2-1:0] PAIR_RST = PW2'(SNR_RESET * SNR_RESET);
  localparam logic [PW3-1:0] CROSS_RST = PW3'(SNR_RESET * SNR_RESET * SNR_RESET);

  // configuration and cross-products
  logic [SNR_BITS-1:0]      snr_r   [NUM_COPIES];
  logic [SNR_BITS-1:0]      mag     [NUM_COPIES];
  logic [PW2-1:0]           pab_r, pcd_r;
  logic [PW3-1:0]           cross_r [NUM_COPIES];
  logic [REFRESH_CNT_W-1:0] refresh_r;

  logic [2*SNR_BITS-1:0]    pab_full, pcd_full;
  logic [3*SNR_BITS-2:0]    cross_full [NUM_COPIES];

  always_comb begin
    for (int i = 0; i < NUM_COPIES; i++) begin
      if (snr_r[i][SNR_BITS-1]) begin
        mag[i] = SNR_BITS'(0) - snr_r[i];
      end else if (snr_r[i] == '0) begin
        mag[i] = SNR_BITS'(1);
      end else begin
        mag[i] = snr_r[i];
      end
    end
  end

  assign pab_full      = mag[CFG_SNR_A] * mag[CFG_SNR_B];
  assign pcd_full      = mag[CFG_SNR_C] * mag[CFG_SNR_D];
  assign cross_full[0] = mag[CFG_SNR_B] * pcd_r;
  assign cross_full[1] = mag[CFG_SNR_A] * pcd_r;
  assign cross_full[2] = mag[CFG_SNR_D] * pab_r;
  assign cross_full[3] = mag[CFG_SNR_C] * pab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COPIES; i++) begin
        snr_r[i]   <= SNR_RST;
        cross_r[i] <= CROSS_RST;
      end
      pab_r     <= PAIR_RST;
      pcd_r     <= PAIR_RST;
      refresh_r <= '0;
    end else begin
      if (cfg_we) begin
        snr_r[cfg_index] <= cfg_data;
        refresh_r        <= REFRESH_CNT_W'(REFRESH_CYCLES);
      end else if (refresh_r != '0) begin
        refresh_r <= refresh_r - 1'b1;
      end
      pab_r <= pab_full[PW2-1:0];
      pcd_r <= pcd_full[PW2-1:0];
      for (int i = 0; i < NUM_COPIES; i++) begin
        cross_r[i] <= cross_full[i][PW3-1:0];
      end
    end
  end

  // request pipeline: input register, then result register
  logic                  s1_valid_r;
  logic [NUM_COPIES-1:0] s1_bits_r;
  logic                  out_valid_r;
  logic                  out_bit_r;
  logic                  s1_adv;
  logic                  in_take;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (refresh_r == '0) && (!s1_valid_r || s1_adv);
  assign in_take     = in_ch.valid && in_ch.ready;

  // weighted vote: k * sum(ones) against (4 - k) * sum(zeros)
  logic [SW-1:0] sum_one, sum_zero;
  logic [2:0]    k_ones, k_zeros;
  logic [VW-1:0] vote_pos, vote_neg;
  logic          decided_nxt;

  always_comb begin
    sum_one  = '0;
    sum_zero = '0;
    k_ones   = '0;
    for (int i = 0; i < NUM_COPIES; i++) begin
      k_ones = k_ones + 3'(s1_bits_r[i]);
      if (s1_bits_r[i]) begin
        sum_one = sum_one + SW'(cross_r[i]);
      end else begin
        sum_zero = sum_zero + SW'(cross_r[i]);
      end
    end
    k_zeros     = 3'(NUM_COPIES) - k_ones;
    vote_pos    = VW'(sum_one) * VW'(k_ones);
    vote_neg    = VW'(sum_zero) * VW'(k_zeros);
    decided_nxt = vote_pos > vote_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_take) begin
      s1_bits_r <= {in_ch.copy_d_bit, in_ch.copy_c_bit,
                    in_ch.copy_b_bit, in_ch.copy_a_bit};
    end
    if (s1_adv) begin
      out_bit_r <= decided_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.decided_bit = out_bit_r;

endmodule

`default_nettype wire
